>>> hdl/avm7_pkg.sv
// Shared types, constants and lookup functions for the averaging voltmeter core.
package avm7_pkg;

  localparam int ADC_BITS            = 10;
  localparam int SAMPLES_PER_READING = 8;   // power of two: the mean is a shift
  localparam int SPR_LOG2            = $clog2(SAMPLES_PER_READING);
  localparam int CNT_W               = SPR_LOG2;
  localparam int SUM_W               = ADC_BITS + SPR_LOG2;

  localparam int FS_W                = 7;
  localparam logic [FS_W-1:0] FS_RESET = 7'd33;

  localparam int ADC_MAX             = (1 << ADC_BITS) - 1;
  localparam int ADC_HALF            = ADC_MAX / 2;
  localparam int PROD_W              = ADC_BITS + FS_W + 1;
  localparam int QUO_W               = PROD_W - ADC_BITS;
  localparam int REM_W               = ADC_BITS + 1;

  localparam int VOLT_W              = 7;
  localparam logic [VOLT_W-1:0] VOLT_MAX = 7'd99;

  localparam int SEG_W               = 7;
  localparam int EN_W                = 2;
  localparam int BCD_W               = 8;

  localparam logic [EN_W-1:0] EN_LOW  = 2'b01;
  localparam logic [EN_W-1:0] EN_HIGH = 2'b10;
  localparam logic [EN_W-1:0] EN_BOTH = 2'b11;

  localparam int IN_TDATA_W          = ((ADC_BITS + 7) / 8) * 8;
  localparam int OUT_FIELDS_W        = SEG_W + EN_W + BCD_W;
  localparam int OUT_TDATA_W         = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W           = OUT_TDATA_W - OUT_FIELDS_W;

  localparam int FIFO_DEPTH          = 4;
  localparam int FIFO_PTR_W          = $clog2(FIFO_DEPTH);

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic                closes_block;
    logic [ADC_BITS-1:0] sample;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  function automatic logic [SEG_W-1:0] seg_lookup(input logic [3:0] digit);
    logic [SEG_W-1:0] seg;
    case (digit)
      4'h0:    seg = 7'h3F;
      4'h1:    seg = 7'h06;
      4'h2:    seg = 7'h5B;
      4'h3:    seg = 7'h4F;
      4'h4:    seg = 7'h66;
      4'h5:    seg = 7'h6D;
      4'h6:    seg = 7'h7D;
      4'h7:    seg = 7'h07;
      4'h8:    seg = 7'h7F;
      4'h9:    seg = 7'h6F;
      4'hA:    seg = 7'h77;
      4'hB:    seg = 7'h7C;
      4'hC:    seg = 7'h39;
      4'hD:    seg = 7'h5E;
      4'hE:    seg = 7'h79;
      default: seg = 7'h71;
    endcase
    return seg;
  endfunction

  // tens = v*205 >> 11, exact for v below 128
  function automatic logic [BCD_W-1:0] bin_to_bcd(input logic [VOLT_W-1:0] v);
    logic [14:0]       p;
    logic [3:0]        tens;
    logic [VOLT_W-1:0] units;
    p     = 15'({8'd0, v}) * 15'd205;
    tens  = p[14:11];
    units = v - {tens, 3'b000} - {2'b00, tens, 1'b0};
    return {tens, units[3:0]};
  endfunction

endpackage

>>> hdl/adc_voltmeter_seven_segment_core.sv
// Top level of the averaging voltmeter with two-digit multiplexed seven-segment drive.
//
// Input stream: in_tuser carries the kind (0 = converter sample, 1 = refresh tick),
// in_tdata[9:0] the raw reading. Every eighth sample the mean is scaled to tenths
// of a volt and latched as two BCD digits; each tick drives one digit, low first.
// Output stream: one result beat per input beat; out_tdata holds segments, digit
// enables and the latched BCD value, out_tuser flags a freshly completed reading.
// Config channel: cfg_data sets full_scale_tenths; always ready; write only when idle.
//
// A beat passes the queue, then the output register; a closing sample also waits on
// the scaling step. Throughput: one beat per cycle while out_tready holds and no
// block is scaling (mean times full scale is registered before the divide by 1023).
// A four-beat queue parts the decode front end from the execution back end, so
// input keeps flowing while the output register waits on out_tready; once the
// queue fills, in_tready drops. Synchronous reset clears the sum, count, digits and
// drive state (segments off, both digits enabled) and restores full scale to 33.
module adc_voltmeter_seven_segment_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic                               in_tuser,   // [0] opcode
  input  logic [avm7_pkg::IN_TDATA_W-1:0]    in_tdata,   // [9:0] sample
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [avm7_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [6:0] segments, [8:7] digit_enable,
                                                         // [16:9] voltage_digits
  output logic                               out_tuser,  // [0] new_reading
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [avm7_pkg::FS_W-1:0]          cfg_data    // full_scale_tenths
);

  logic            push;
  logic            pop;
  logic            fifo_full;
  avm7_pkg::item_t item;
  avm7_pkg::head_t head;

  avm7_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .fifo_full (fifo_full),
    .push      (push),
    .item      (item)
  );

  avm7_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .item  (item),
    .pop   (pop),
    .full  (fifo_full),
    .head  (head)
  );

  avm7_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> hdl/avm7_front.sv
// Front end: accepts input beats, decodes the item kind and tags the sample that closes a block.
module avm7_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic                               in_tuser,   // [0] opcode
  input  logic [avm7_pkg::IN_TDATA_W-1:0]    in_tdata,   // [ADC_BITS-1:0] sample
  input  logic                               fifo_full,
  output logic                               push,
  output avm7_pkg::item_t                    item
);

  logic [avm7_pkg::CNT_W-1:0] count_r;
  logic [avm7_pkg::CNT_W-1:0] count_nxt;
  logic                       is_sample;
  logic                       closes;

  assign in_tready = !fifo_full;
  assign push      = in_tvalid && in_tready;
  assign is_sample = (avm7_pkg::op_t'(in_tuser) == avm7_pkg::OP_SAMPLE);
  assign closes    = is_sample &&
                     (count_r == avm7_pkg::CNT_W'(avm7_pkg::SAMPLES_PER_READING - 1));

  always_comb begin
    item.op           = avm7_pkg::op_t'(in_tuser);
    item.closes_block = closes;
    item.sample       = in_tdata[avm7_pkg::ADC_BITS-1:0];  // upper bits ignored
  end

  always_comb begin
    count_nxt = count_r;
    if (push && is_sample) begin
      count_nxt = closes ? '0 : count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

>>> hdl/avm7_fifo.sv
// Short queue of decoded items between the front end and the execution back end.
module avm7_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  avm7_pkg::item_t  item,
  input  logic             pop,
  output logic             full,
  output avm7_pkg::head_t  head
);

  avm7_pkg::item_t                mem [avm7_pkg::FIFO_DEPTH];
  logic [avm7_pkg::FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [avm7_pkg::FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [avm7_pkg::FIFO_PTR_W:0]   count_r, count_nxt;

  assign full       = (count_r == (avm7_pkg::FIFO_PTR_W+1)'(avm7_pkg::FIFO_DEPTH));
  assign head.valid = (count_r != '0);
  assign head.item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hdl/avm7_back.sv
// Back end: accumulates samples, scales each block to BCD, drives the display and registers results.
module avm7_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [avm7_pkg::FS_W-1:0]           cfg_data,    // full_scale_tenths
  input  avm7_pkg::head_t                     head,
  output logic                                pop,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [avm7_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tuser
);

  logic [avm7_pkg::FS_W-1:0]        fs_r, fs_nxt;
  logic [avm7_pkg::SUM_W-1:0]       sum_r, sum_nxt;
  logic [avm7_pkg::BCD_W-1:0]       bcd_r, bcd_nxt;
  logic                             show_high_r, show_high_nxt;
  logic [avm7_pkg::SEG_W-1:0]       seg_r, seg_nxt;
  logic [avm7_pkg::EN_W-1:0]        en_r, en_nxt;
  logic [avm7_pkg::PROD_W-1:0]      prod_r, prod_nxt;
  logic                             conv_r, conv_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [avm7_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                             out_user_r, out_user_nxt;

  logic                             adv;
  logic [avm7_pkg::SUM_W-1:0]       sum_ext;
  logic [avm7_pkg::ADC_BITS-1:0]    mean;
  logic [avm7_pkg::PROD_W-1:0]      rounded;
  logic [avm7_pkg::QUO_W-1:0]       q0;
  logic [avm7_pkg::REM_W-1:0]       r0;
  logic [avm7_pkg::QUO_W-1:0]       quo;
  logic [avm7_pkg::VOLT_W-1:0]      volt;
  logic [avm7_pkg::BCD_W-1:0]       new_bcd;
  logic [3:0]                       digit;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign adv     = !out_valid_r || out_tready;
  assign sum_ext = sum_r + avm7_pkg::SUM_W'(head.item.sample);
  assign mean    = sum_ext[avm7_pkg::SUM_W-1:avm7_pkg::SPR_LOG2];

  // divide by 2^N-1: x = 2^N*q0 + lo = (2^N-1)*q0 + (q0+lo), one correction step
  assign rounded = prod_r + avm7_pkg::PROD_W'(avm7_pkg::ADC_HALF);
  assign q0      = rounded[avm7_pkg::PROD_W-1:avm7_pkg::ADC_BITS];
  assign r0      = {1'b0, rounded[avm7_pkg::ADC_BITS-1:0]} + avm7_pkg::REM_W'(q0);
  assign quo     = q0 + avm7_pkg::QUO_W'(r0 >= avm7_pkg::REM_W'(avm7_pkg::ADC_MAX));
  assign volt    = (quo > avm7_pkg::QUO_W'(avm7_pkg::VOLT_MAX)) ? avm7_pkg::VOLT_MAX
                                                                 : quo[avm7_pkg::VOLT_W-1:0];
  assign new_bcd = avm7_pkg::bin_to_bcd(volt);
  assign digit   = show_high_r ? bcd_r[7:4] : bcd_r[3:0];

  always_comb begin
    fs_nxt        = cfg_valid ? cfg_data : fs_r;
    sum_nxt       = sum_r;
    bcd_nxt       = bcd_r;
    show_high_nxt = show_high_r;
    seg_nxt       = seg_r;
    en_nxt        = en_r;
    prod_nxt      = prod_r;
    conv_nxt      = conv_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    pop           = 1'b0;

    if (conv_r) begin
      // closing sample with its product registered: finish scaling and post the reading
      if (adv) begin
        bcd_nxt       = new_bcd;
        conv_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
        out_data_nxt  = {{avm7_pkg::OUT_PAD_W{1'b0}}, new_bcd, en_r, seg_r};
        out_user_nxt  = 1'b1;
      end
    end else if (head.valid && adv) begin
      pop = 1'b1;
      case (head.item.op)
        avm7_pkg::OP_TICK: begin
          en_nxt        = show_high_r ? avm7_pkg::EN_HIGH : avm7_pkg::EN_LOW;
          seg_nxt       = avm7_pkg::seg_lookup(digit);
          show_high_nxt = !show_high_r;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{avm7_pkg::OUT_PAD_W{1'b0}}, bcd_r, en_nxt, seg_nxt};
          out_user_nxt  = 1'b0;
        end
        avm7_pkg::OP_SAMPLE: begin
          if (head.item.closes_block) begin
            prod_nxt = avm7_pkg::PROD_W'(mean) * avm7_pkg::PROD_W'(fs_r);
            sum_nxt  = '0;
            conv_nxt = 1'b1;
          end else begin
            sum_nxt       = sum_ext;
            out_valid_nxt = 1'b1;
            out_data_nxt  = {{avm7_pkg::OUT_PAD_W{1'b0}}, bcd_r, en_r, seg_r};
            out_user_nxt  = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r        <= avm7_pkg::FS_RESET;
      sum_r       <= '0;
      bcd_r       <= '0;
      show_high_r <= 1'b0;
      seg_r       <= '0;
      en_r        <= avm7_pkg::EN_BOTH;
      conv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fs_r        <= fs_nxt;
      sum_r       <= sum_nxt;
      bcd_r       <= bcd_nxt;
      show_high_r <= show_high_nxt;
      seg_r       <= seg_nxt;
      en_r        <= en_nxt;
      conv_r      <= conv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

>>> hdl/avm7_checker.sv
// Port-level checker for the voltmeter core, bound to the top level.
module avm7_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [avm7_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // latched reading is always two decimal digits
  a_bcd_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[16:13] <= 4'd9) && (out_tdata[12:9] <= 4'd9))
    else $error("voltage digits not decimal");

  // some digit is always enabled
  a_enable_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8:7] != 2'b00)
    else $error("no digit enabled");

  // nothing is posted in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind adc_voltmeter_seven_segment_core avm7_checker u_avm7_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
